/* hw/rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// Types and constants shared by the spin loop and liveness monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package slm_pkg;

  localparam int unsigned CycW   = 64;
  localparam int unsigned CntW   = 32;
  localparam int unsigned CtxW   = 7;
  localparam int unsigned CfgIdW = 2;
  // base timeout (32 bits) times at most 64 context pairs
  localparam int unsigned LimW   = 39;

  localparam logic [31:0]     TimeoutRst = 32'd1000000;
  localparam logic [CtxW-1:0] HwCtxRst   = 7'd1;
  localparam logic            WdogRst    = 1'b1;

  typedef enum logic {
    OP_COMMIT = 1'b0,
    OP_CHECK  = 1'b1
  } op_e;

  typedef enum logic [CfgIdW-1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_HW_CTX  = 2'd1,
    CFG_WDOG_EN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CLS_USER   = 2'd0,
    CLS_KERNEL = 2'd1,
    CLS_IDLE   = 2'd2
  } spin_cls_e;

  typedef logic [2:0][CntW-1:0] trip_vec_t;
  typedef logic [2:0][CycW-1:0] span_vec_t;

  // One macro-boundary update for the spin tracker
  typedef struct packed {
    logic            apply;
    logic            pause;
    spin_cls_e       cls;
    logic [CycW-1:0] now;
    logic [CycW-1:0] span;
  } spin_req_t;

endpackage

`default_nettype wire

/* hw/rtl/slm_spin_track.sv */
// ----------------------------------------------------------------------------
// slm_spin_track
// Spin loop detector: pause ops at macro boundaries enter and keep a loop,
// a run of macro ops without a pause leaves it. Trips and cycles per class.
// ----------------------------------------------------------------------------
`default_nettype none

module slm_spin_track import slm_pkg::*; #(
  parameter int unsigned SPIN_EXIT_LIMIT = 50
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire spin_req_t       req_i,
  output logic [CycW-1:0]      start_o,
  output logic                 active_o,
  output trip_vec_t            trips_o,
  output span_vec_t            totals_o
);

  localparam logic [8:0] ExitLim = 9'(SPIN_EXIT_LIMIT);

  logic            active_q, active_d;
  logic [CycW-1:0] start_q, start_d;
  logic [7:0]      ops_q, ops_d;
  trip_vec_t       trips_q, trips_d;
  span_vec_t       totals_q, totals_d;
  logic [8:0]      ops_inc;

  assign ops_inc = {1'b0, ops_q} + 9'd1;

  always_comb begin
    active_d = active_q;
    start_d  = start_q;
    ops_d    = ops_q;
    trips_d  = trips_q;
    totals_d = totals_q;
    if (req_i.apply) begin
      if (req_i.pause) begin
        start_d  = req_i.now;
        ops_d    = '0;
        active_d = 1'b1;
        if (active_q) begin
          for (int i = 0; i < 3; i++) begin
            if (req_i.cls == spin_cls_e'(i)) begin
              trips_d[i]  = trips_q[i] + 32'd1;
              totals_d[i] = totals_q[i] + req_i.span;
            end
          end
        end
      end else if (active_q) begin
        // leave the loop once too many ops pass without a pause
        if (ops_inc > ExitLim) begin
          active_d = 1'b0;
        end
        ops_d = ops_inc[8] ? 8'hFF : ops_inc[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      start_q  <= '0;
      ops_q    <= '0;
      trips_q  <= '0;
      totals_q <= '0;
    end else begin
      active_q <= active_d;
      start_q  <= start_d;
      ops_q    <= ops_d;
      trips_q  <= trips_d;
      totals_q <= totals_d;
    end
  end

  assign start_o  = start_q;
  assign active_o = active_q;
  assign trips_o  = trips_q;
  assign totals_o = totals_q;

  // trips only count inside a loop that was already running
  a_trip_needs_loop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trips_q != $past(trips_q)) |-> $past(active_q))
    else $error("spin trip counted outside a spin loop");

  // a pause always leaves the tracker in a loop with a cleared run length
  a_pause_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.apply && req_i.pause) |=> (active_q && ops_q == 8'd0))
    else $error("pause op did not restart the spin loop");

  // a loop is only left after a run of ops past the exit limit
  a_exit_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> ({1'b0, $past(ops_q)} >= ExitLim))
    else $error("spin loop left before the exit limit");

endmodule

`default_nettype wire

/* hw/rtl/spin_loop_and_liveness_monitor.sv */
// ----------------------------------------------------------------------------
// spin_loop_and_liveness_monitor
// Per-thread monitor of timer interrupts, spin loops and commit liveness.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result channel is not stalled. A
// request is captured in an input register, where the cycle differences
// against the last commit, the interrupt start and the spin loop start are
// formed (forwarded from the request ahead of it) along with the liveness
// limit; as the request leaves the input register the state is updated and
// the result is loaded into the output register. Result fields show the
// counters as left by that request and are held while the output is
// stalled. Configuration writes are always ready and take effect on the
// next request.
`default_nettype none

module spin_loop_and_liveness_monitor import slm_pkg::*; #(
  parameter int unsigned SPIN_EXIT_LIMIT = 50
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // request channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              operation_i,
  input  wire logic [CycW-1:0]   now_cycle_i,
  input  wire logic              has_context_i,
  input  wire logic              sw_in_timer_irq_i,
  input  wire logic              end_of_macro_i,
  input  wire logic              is_pause_i,
  input  wire logic              is_idle_pause_i,
  input  wire logic              is_kernel_i,
  input  wire logic [CtxW-1:0]   active_sw_contexts_i,
  // result channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   timeout_flag_o,
  output logic                   spinning_o,
  output logic                   in_timer_irq_o,
  output logic [CntW-1:0]        timer_irq_count_o,
  output logic [CycW-1:0]        timer_irq_cycles_o,
  output logic [CntW-1:0]        user_spin_trips_o,
  output logic [CycW-1:0]        user_spin_cycles_o,
  output logic [CntW-1:0]        kernel_spin_trips_o,
  output logic [CycW-1:0]        kernel_spin_cycles_o,
  output logic [CntW-1:0]        idle_spin_trips_o,
  output logic [CycW-1:0]        idle_spin_cycles_o,
  // configuration write channel
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgIdW-1:0] cfg_index_i,
  input  wire logic [31:0]       cfg_data_i
);

  // configuration
  logic [31:0]     timeout_q;
  logic [CtxW-1:0] hw_ctx_q;
  logic            wdog_q;

  // input register
  logic            s1_valid_q;
  op_e             s1_op_q;
  logic [CycW-1:0] s1_now_q;
  logic            s1_ctx_q, s1_swirq_q, s1_eom_q, s1_pause_q;
  spin_cls_e       s1_cls_q;
  logic [CycW-1:0] s1_elapsed_q, s1_irq_span_q, s1_spin_span_q;
  logic [LimW-1:0] s1_limit_q;

  // architectural state
  logic [CycW-1:0] last_commit_q;
  logic            irq_active_q;
  logic [CycW-1:0] irq_start_q;
  logic [CntW-1:0] irq_count_q;
  logic [CycW-1:0] irq_total_q;
  logic            timeout_flag_q;
  logic            out_valid_q;

  logic            in_acc, s1_adv, s1_commit;
  logic            irq_toggle;
  logic [CycW-1:0] last_eff, irq_start_eff, spin_start_eff, spin_start;
  logic [CtxW-1:0] act_min, act_cl, act_m1;
  logic [6:0]      mult;
  logic [LimW-1:0] limit_d;
  spin_cls_e       cls_d;
  spin_req_t       spin_req;
  logic            spin_active;
  trip_vec_t       spin_trips;
  span_vec_t       spin_totals;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign s1_commit  = s1_valid_q && (s1_op_q == OP_COMMIT);
  assign irq_toggle = s1_commit && s1_ctx_q && (s1_swirq_q != irq_active_q);

  // forward the start marks that the request ahead is about to write
  assign last_eff       = s1_commit ? s1_now_q : last_commit_q;
  assign irq_start_eff  = (irq_toggle && !irq_active_q) ? s1_now_q : irq_start_q;
  assign spin_start_eff = (s1_commit && s1_eom_q && s1_pause_q) ? s1_now_q : spin_start;

  // liveness limit: T * (1 + (active - 1) / 2), active clamped to [1, hw]
  assign act_min = (active_sw_contexts_i < hw_ctx_q) ? active_sw_contexts_i : hw_ctx_q;
  assign act_cl  = (act_min == '0) ? CtxW'(1) : act_min;
  assign act_m1  = act_cl - CtxW'(1);
  assign mult    = {1'b0, act_m1[CtxW-1:1]} + 7'd1;
  assign limit_d = LimW'(timeout_q) * LimW'(mult);

  always_comb begin
    if (is_idle_pause_i) begin
      cls_d = CLS_IDLE;
    end else if (is_kernel_i) begin
      cls_d = CLS_KERNEL;
    end else begin
      cls_d = CLS_USER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      hw_ctx_q  <= HwCtxRst;
      wdog_q    <= WdogRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_TIMEOUT: timeout_q <= cfg_data_i;
        CFG_HW_CTX:  hw_ctx_q  <= cfg_data_i[CtxW-1:0];
        CFG_WDOG_EN: wdog_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_op_q        <= op_e'(operation_i);
      s1_now_q       <= now_cycle_i;
      s1_ctx_q       <= has_context_i;
      s1_swirq_q     <= sw_in_timer_irq_i;
      s1_eom_q       <= end_of_macro_i;
      s1_pause_q     <= is_pause_i;
      s1_cls_q       <= cls_d;
      s1_elapsed_q   <= now_cycle_i - last_eff;
      s1_irq_span_q  <= now_cycle_i - irq_start_eff;
      s1_spin_span_q <= now_cycle_i - spin_start_eff;
      s1_limit_q     <= limit_d;
    end
  end

  // state update as the request leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_commit_q  <= '0;
      irq_active_q   <= 1'b0;
      irq_start_q    <= '0;
      irq_count_q    <= '0;
      irq_total_q    <= '0;
      timeout_flag_q <= 1'b0;
    end else if (s1_adv) begin
      timeout_flag_q <= (s1_op_q == OP_CHECK) && wdog_q &&
                        (s1_elapsed_q >= CycW'(s1_limit_q));
      if (s1_commit) begin
        last_commit_q <= s1_now_q;
      end
      if (irq_toggle) begin
        irq_active_q <= !irq_active_q;
        if (irq_active_q) begin
          irq_count_q <= irq_count_q + 32'd1;
          irq_total_q <= irq_total_q + s1_irq_span_q;
        end else begin
          irq_start_q <= s1_now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign spin_req.apply = s1_adv && s1_commit && s1_eom_q;
  assign spin_req.pause = s1_pause_q;
  assign spin_req.cls   = s1_cls_q;
  assign spin_req.now   = s1_now_q;
  assign spin_req.span  = s1_spin_span_q;

  slm_spin_track #(
    .SPIN_EXIT_LIMIT(SPIN_EXIT_LIMIT)
  ) u_spin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (spin_req),
    .start_o (spin_start),
    .active_o(spin_active),
    .trips_o (spin_trips),
    .totals_o(spin_totals)
  );

  // state only moves when a result is loaded, so it doubles as the result
  assign out_valid_o          = out_valid_q;
  assign timeout_flag_o       = timeout_flag_q;
  assign spinning_o           = spin_active;
  assign in_timer_irq_o       = irq_active_q;
  assign timer_irq_count_o    = irq_count_q;
  assign timer_irq_cycles_o   = irq_total_q;
  assign user_spin_trips_o    = spin_trips[CLS_USER];
  assign user_spin_cycles_o   = spin_totals[CLS_USER];
  assign kernel_spin_trips_o  = spin_trips[CLS_KERNEL];
  assign kernel_spin_cycles_o = spin_totals[CLS_KERNEL];
  assign idle_spin_trips_o    = spin_trips[CLS_IDLE];
  assign idle_spin_cycles_o   = spin_totals[CLS_IDLE];

  a_irq_count_on_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (irq_count_q != $past(irq_count_q)) |-> $fell(irq_active_q))
    else $error("timer interrupt counted without an exit");

  a_commit_no_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_op_q == OP_COMMIT) |=> !timeout_flag_o)
    else $error("timeout flagged on a commit request");

  a_state_held_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=>
      ($stable(last_commit_q) && $stable(irq_count_q) && $stable(irq_total_q)))
    else $error("state changed while result was stalled");

  a_no_result_from_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !s1_valid_q) |=> !out_valid_q)
    else $error("result produced with no request in flight");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the spin loop and liveness monitor.
// ----------------------------------------------------------------------------
// Drives commits and liveness checks through the request channel with random
// gaps and output stalls. An in-bench model of the interrupt tracker, the spin
// loop heuristic and the liveness limit predicts every status word, and each
// accepted result is compared field by field against the oldest prediction.
// Directed cases cover reset values, interrupt entry and exit with cycle wrap,
// the spin classes and the timeout limit at its edges; random phases then run
// well-formed spin loops with exits around the limit, interrupt toggles and
// checks placed right at the limit, under several register settings.
// ----------------------------------------------------------------------------

module tb_top;
  import slm_pkg::*;

  localparam int unsigned SpinLimit = 50;
  localparam int unsigned Latency   = 2;
  localparam int unsigned HoldLen   = 200;
  localparam int unsigned QuietMax  = 2000;
  localparam int unsigned PhaseLen  = 100;

  typedef struct packed {
    op_e             op;
    logic [CycW-1:0] now;
    logic            ctx;
    logic            sw_irq;
    logic            eom;
    logic            pause;
    logic            idle;
    logic            kern;
    logic [CtxW-1:0] active;
  } mon_event_t;

  typedef struct packed {
    logic            timeout;
    logic            spinning;
    logic            in_irq;
    logic [CntW-1:0] irq_cnt;
    logic [CycW-1:0] irq_cyc;
    trip_vec_t       trips;
    span_vec_t       spans;
  } status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              operation_i;
  logic [CycW-1:0]   now_cycle_i;
  logic              has_context_i;
  logic              sw_in_timer_irq_i;
  logic              end_of_macro_i;
  logic              is_pause_i;
  logic              is_idle_pause_i;
  logic              is_kernel_i;
  logic [CtxW-1:0]   active_sw_contexts_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              timeout_flag_o;
  logic              spinning_o;
  logic              in_timer_irq_o;
  logic [CntW-1:0]   timer_irq_count_o;
  logic [CycW-1:0]   timer_irq_cycles_o;
  logic [CntW-1:0]   user_spin_trips_o;
  logic [CycW-1:0]   user_spin_cycles_o;
  logic [CntW-1:0]   kernel_spin_trips_o;
  logic [CycW-1:0]   kernel_spin_cycles_o;
  logic [CntW-1:0]   idle_spin_trips_o;
  logic [CycW-1:0]   idle_spin_cycles_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgIdW-1:0] cfg_index_i;
  logic [31:0]       cfg_data_i;

  spin_loop_and_liveness_monitor #(
    .SPIN_EXIT_LIMIT(SpinLimit)
  ) uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .operation_i          (operation_i),
    .now_cycle_i          (now_cycle_i),
    .has_context_i        (has_context_i),
    .sw_in_timer_irq_i    (sw_in_timer_irq_i),
    .end_of_macro_i       (end_of_macro_i),
    .is_pause_i           (is_pause_i),
    .is_idle_pause_i      (is_idle_pause_i),
    .is_kernel_i          (is_kernel_i),
    .active_sw_contexts_i (active_sw_contexts_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .timeout_flag_o       (timeout_flag_o),
    .spinning_o           (spinning_o),
    .in_timer_irq_o       (in_timer_irq_o),
    .timer_irq_count_o    (timer_irq_count_o),
    .timer_irq_cycles_o   (timer_irq_cycles_o),
    .user_spin_trips_o    (user_spin_trips_o),
    .user_spin_cycles_o   (user_spin_cycles_o),
    .kernel_spin_trips_o  (kernel_spin_trips_o),
    .kernel_spin_cycles_o (kernel_spin_cycles_o),
    .idle_spin_trips_o    (idle_spin_trips_o),
    .idle_spin_cycles_o   (idle_spin_cycles_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Monitor state as the block should hold it
  logic [CycW-1:0] m_last_commit;
  logic            m_irq_on;
  logic [CycW-1:0] m_irq_start;
  logic [CntW-1:0] m_irq_cnt;
  logic [CycW-1:0] m_irq_cyc;
  logic            m_spin_on;
  logic [CycW-1:0] m_spin_start;
  logic [7:0]      m_ops_gap;
  trip_vec_t       m_trips;
  span_vec_t       m_spans;
  logic [31:0]     m_timeout;
  logic [CtxW-1:0] m_hw_ctx;
  logic            m_wdog;

  status_t         status_q[$];
  int unsigned     mismatch_count;
  int unsigned     quiet_cycles;

  // Stimulus bookkeeping
  logic [CycW-1:0] cyc;
  logic [CycW-1:0] last_commit_sent;
  logic            irq_level;
  logic            tx_idle;
  logic            rx_idle;
  logic            rx_hold_req;

  function automatic logic [CycW-1:0] liveness_limit(logic [CtxW-1:0] req_active);
    logic [CtxW-1:0] act;
    logic [CycW-1:0] base;
    act = (m_hw_ctx < req_active) ? m_hw_ctx : req_active;
    if (act == '0) act = 7'd1;
    base = {32'd0, m_timeout};
    return base + base * {57'd0, (act - 7'd1) >> 1};
  endfunction

  function automatic status_t predict_status(mon_event_t e);
    status_t   s;
    logic [8:0] n;
    spin_cls_e cls;
    s = '0;
    if (e.op == OP_CHECK) begin
      s.timeout = m_wdog && ((e.now - m_last_commit) >= liveness_limit(e.active));
    end else begin
      m_last_commit = e.now;
      if (e.ctx && (e.sw_irq != m_irq_on)) begin
        if (m_irq_on) begin
          m_irq_on  = 1'b0;
          m_irq_cnt = m_irq_cnt + 1'b1;
          m_irq_cyc = m_irq_cyc + (e.now - m_irq_start);
        end else begin
          m_irq_on    = 1'b1;
          m_irq_start = e.now;
        end
      end
      if (e.eom) begin
        if (m_spin_on) begin
          n = {1'b0, m_ops_gap} + 9'd1;
          if (e.pause) begin
            cls = e.idle ? CLS_IDLE : (e.kern ? CLS_KERNEL : CLS_USER);
            m_trips[cls] = m_trips[cls] + 1'b1;
            m_spans[cls] = m_spans[cls] + (e.now - m_spin_start);
            m_spin_start = e.now;
            m_ops_gap    = '0;
          end else begin
            if (n > SpinLimit) m_spin_on = 1'b0;
            m_ops_gap = (n > 9'd255) ? 8'hFF : n[7:0];
          end
        end else if (e.pause) begin
          m_spin_start = e.now;
          m_ops_gap    = '0;
          m_spin_on    = 1'b1;
        end
      end
    end
    s.spinning = m_spin_on;
    s.in_irq   = m_irq_on;
    s.irq_cnt  = m_irq_cnt;
    s.irq_cyc  = m_irq_cyc;
    s.trips    = m_trips;
    s.spans    = m_spans;
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: mismatch on %s: expected %h, got %h", $realtime, name, want, got);
    end
  endfunction

  // Predict on request acceptance, compare on result acceptance
  always @(posedge clk_i) begin : scoreboard
    mon_event_t e;
    status_t    want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      e.op     = op_e'(operation_i);
      e.now    = now_cycle_i;
      e.ctx    = has_context_i;
      e.sw_irq = sw_in_timer_irq_i;
      e.eom    = end_of_macro_i;
      e.pause  = is_pause_i;
      e.idle   = is_idle_pause_i;
      e.kern   = is_kernel_i;
      e.active = active_sw_contexts_i;
      status_q.push_back(predict_status(e));
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = status_q.pop_front();
        check_field("timeout_flag", 64'(want.timeout), 64'(timeout_flag_o));
        check_field("spinning", 64'(want.spinning), 64'(spinning_o));
        check_field("in_timer_irq", 64'(want.in_irq), 64'(in_timer_irq_o));
        check_field("timer_irq_count", 64'(want.irq_cnt), 64'(timer_irq_count_o));
        check_field("timer_irq_cycles", want.irq_cyc, timer_irq_cycles_o);
        check_field("user_spin_trips", 64'(want.trips[CLS_USER]), 64'(user_spin_trips_o));
        check_field("user_spin_cycles", want.spans[CLS_USER], user_spin_cycles_o);
        check_field("kernel_spin_trips", 64'(want.trips[CLS_KERNEL]),
                    64'(kernel_spin_trips_o));
        check_field("kernel_spin_cycles", want.spans[CLS_KERNEL], kernel_spin_cycles_o);
        check_field("idle_spin_trips", 64'(want.trips[CLS_IDLE]), 64'(idle_spin_trips_o));
        check_field("idle_spin_cycles", want.spans[CLS_IDLE], idle_spin_cycles_o);
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietMax) begin
      $display("[spin_loop_and_liveness_monitor] ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold when asked
  always begin : result_sink
    int hold;
    if (rx_hold_req) begin
      hold        = HoldLen;
      rx_hold_req = 1'b0;
    end else begin
      hold = (rx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    end
    if (hold > 0) begin
      @(negedge clk_i);
      out_stall_i = 1'b1;
      repeat (hold - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    out_stall_i = 1'b0;
    @(posedge clk_i);
    while (!out_valid_o) @(posedge clk_i);
  end

  task automatic issue_event(mon_event_t e);
    int gap;
    gap = (tx_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    operation_i          = e.op;
    now_cycle_i          = e.now;
    has_context_i        = e.ctx;
    sw_in_timer_irq_i    = e.sw_irq;
    end_of_macro_i       = e.eom;
    is_pause_i           = e.pause;
    is_idle_pause_i      = e.idle;
    is_kernel_i          = e.kern;
    active_sw_contexts_i = e.active;
    in_valid_i           = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (e.op == OP_COMMIT) last_commit_sent = e.now;
  endtask

  task automatic commit_op(logic [CycW-1:0] now, logic ctx, logic irq, logic eom,
                           logic pause, logic idle, logic kern);
    mon_event_t e;
    e.op     = OP_COMMIT;
    e.now    = now;
    e.ctx    = ctx;
    e.sw_irq = irq;
    e.eom    = eom;
    e.pause  = pause;
    e.idle   = idle;
    e.kern   = kern;
    e.active = CtxW'($urandom_range(0, 64));
    issue_event(e);
  endtask

  task automatic live_check(logic [CycW-1:0] now, logic [CtxW-1:0] act);
    mon_event_t e;
    e.op     = OP_CHECK;
    e.now    = now;
    e.ctx    = 1'($urandom_range(0, 1));
    e.sw_irq = 1'($urandom_range(0, 1));
    e.eom    = 1'($urandom_range(0, 1));
    e.pause  = 1'($urandom_range(0, 1));
    e.idle   = 1'($urandom_range(0, 1));
    e.kern   = 1'($urandom_range(0, 1));
    e.active = act;
    issue_event(e);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TIMEOUT: m_timeout = data;
      CFG_HW_CTX:  m_hw_ctx  = data[CtxW-1:0];
      CFG_WDOG_EN: m_wdog    = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic advance_cycle();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) cyc = {$urandom, $urandom};
    else if (r == 1) cyc = '1 - CycW'($urandom_range(0, 30));
    else cyc = cyc + CycW'($urandom_range(1, 40));
  endtask

  // Place the check just below, at or above the limit, or far away
  task automatic probe_liveness();
    logic [CtxW-1:0] act;
    logic [CycW-1:0] lim;
    logic [CycW-1:0] delta;
    act = CtxW'($urandom_range(0, 64));
    lim = liveness_limit(act);
    case ($urandom_range(0, 4))
      0:       delta = lim - 1'b1;
      1:       delta = lim;
      2:       delta = lim + 1'b1;
      3:       delta = {32'd0, $urandom};
      default: delta = {$urandom, $urandom};
    endcase
    live_check(last_commit_sent + delta, act);
  endtask

  task automatic random_commit();
    logic irq;
    advance_cycle();
    irq = ($urandom_range(0, 19) == 0) ? 1'($urandom_range(0, 1)) : irq_level;
    commit_op(cyc, $urandom_range(0, 5) != 0, irq, $urandom_range(0, 7) != 0,
              $urandom_range(0, 2) == 0, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic random_burst(int count);
    int done;
    int run;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // enter a loop, then go quiet for a stretch around the exit limit
        advance_cycle();
        commit_op(cyc, 1'b1, irq_level, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        run = $urandom_range(SpinLimit - 5, SpinLimit + 6);
        repeat (run) begin
          advance_cycle();
          commit_op(cyc, 1'($urandom_range(0, 1)), irq_level, 1'b1, 1'b0,
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        done += run + 1;
      end else if (pick < 30) begin
        probe_liveness();
        done++;
      end else if (pick < 38) begin
        irq_level = ~irq_level;
        advance_cycle();
        commit_op(cyc, 1'b1, irq_level, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        done++;
      end else begin
        random_commit();
        done++;
      end
    end
  endtask

  task automatic test_reset_values();
    live_check(64'd0, 7'd0);
    live_check(64'd999999, 7'd1);
    live_check(64'd1000000, 7'd64);
  endtask

  task automatic test_timer_irq();
    commit_op(64'd100, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    // no context: the flag is not followed
    commit_op(64'd150, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    commit_op(64'd300, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    commit_op(64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    commit_op(64'h10, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    commit_op('1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_spin_classes();
    commit_op(64'd990, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
    commit_op(64'd995, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    commit_op(64'd1000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    commit_op(64'd1010, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
    commit_op(64'd1030, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
    commit_op(64'd1060, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    // idle takes priority over kernel
    commit_op(64'd1100, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    commit_op(64'd1105, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    commit_op(64'd1000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_liveness();
    write_reg(CFG_TIMEOUT, 32'd5);
    write_reg(CFG_HW_CTX, 32'hFFFF_FFC0);
    commit_op(64'd1000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    live_check(64'd1004, 7'd1);
    live_check(64'd1005, 7'd0);
    live_check(64'd1159, 7'd64);
    live_check(64'd1160, 7'd64);
    live_check(64'd1009, 7'd3);
    // check behind the last commit wraps to a huge gap
    live_check(64'd999, 7'd2);
    write_reg(CFG_WDOG_EN, 32'd0);
    live_check(64'd5000, 7'd64);
    write_reg(CFG_WDOG_EN, 32'd3);
    write_reg(CFG_TIMEOUT, 32'd0);
    live_check(64'd1000, 7'd1);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    live_check(last_commit_sent + liveness_limit(7'd64) - 1'b1, 7'd64);
    live_check(last_commit_sent + liveness_limit(7'd64), 7'd64);
    write_reg(CFG_HW_CTX, 32'd2);
    live_check(last_commit_sent + 64'hFFFF_FFFF, 7'd64);
  endtask

  task automatic test_backpressure();
    wait_idle();
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    rx_hold_req = 1'b1;
    random_burst(40);
    // let every result drain before sending again
    wait_idle();
    random_burst(10);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_TIMEOUT, 32'($urandom_range(1, 60)));
          write_reg(CFG_HW_CTX, 32'($urandom_range(1, 64)));
          write_reg(CFG_WDOG_EN, 32'd1);
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
          write_reg(CFG_HW_CTX, 32'd64);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
        2: begin
          write_reg(CFG_TIMEOUT, 32'd1);
          write_reg(CFG_HW_CTX, 32'd1);
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        3: begin
          write_reg(CFG_WDOG_EN, 32'd0);
          write_reg(CFG_TIMEOUT, $urandom);
          tx_idle = 1'b0;
          rx_idle = 1'b1;
        end
        default: begin
          write_reg(CFG_WDOG_EN, 32'd1);
          write_reg(CFG_TIMEOUT, 32'($urandom_range(1, 1000)));
          write_reg(CFG_HW_CTX, 32'($urandom_range(1, 64)));
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
      endcase
      random_burst(PhaseLen);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    operation_i          = OP_COMMIT;
    now_cycle_i          = '0;
    has_context_i        = 1'b0;
    sw_in_timer_irq_i    = 1'b0;
    end_of_macro_i       = 1'b0;
    is_pause_i           = 1'b0;
    is_idle_pause_i      = 1'b0;
    is_kernel_i          = 1'b0;
    active_sw_contexts_i = '0;
    out_stall_i          = 1'b0;
    cfg_valid_i          = 1'b0;
    cfg_index_i          = CFG_TIMEOUT;
    cfg_data_i           = '0;
    m_last_commit        = '0;
    m_irq_on             = 1'b0;
    m_irq_start          = '0;
    m_irq_cnt            = '0;
    m_irq_cyc            = '0;
    m_spin_on            = 1'b0;
    m_spin_start         = '0;
    m_ops_gap            = '0;
    m_trips              = '0;
    m_spans              = '0;
    m_timeout            = TimeoutRst;
    m_hw_ctx             = HwCtxRst;
    m_wdog               = WdogRst;
    mismatch_count       = 0;
    quiet_cycles         = 0;
    cyc                  = 64'd2000;
    last_commit_sent     = '0;
    irq_level            = 1'b0;
    tx_idle              = 1'b1;
    rx_idle              = 1'b1;
    rx_hold_req          = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_values();
    test_timer_irq();
    test_spin_classes();
    test_liveness();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    repeat (Latency + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[spin_loop_and_liveness_monitor] OK");
    end else begin
      $display("[spin_loop_and_liveness_monitor] ERROR");
    end
    $finish;
  end

endmodule
